// ----- hw/rtl/cyclic_bracket_match_flip_core_macros.svh -----
// assertion macros for the cyclic bracket match flip core
// expects signals named clk and arst_n in the including module
`ifndef CYCLIC_BRACKET_MATCH_FLIP_CORE_MACROS_SVH
`define CYCLIC_BRACKET_MATCH_FLIP_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define CBMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CBMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/cbmf_pkg.sv -----
// shared constants and types for the cyclic bracket match flip core
// no dependencies
package cbmf_pkg;

	// widths of the word, positions and the length register
	localparam int MAX_BITS = 32;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 6;

	// prefix sums are kept with an offset so they stay unsigned
	localparam int OFF_W = 7;
	localparam logic [OFF_W-1:0] P_OFFSET = 7'(MAX_BITS);

	// a total of +1 or -1 as offset values
	localparam logic [OFF_W-1:0] TOTAL_PLUS  = 7'(MAX_BITS + 1);
	localparam int               TOTAL_MINUS_I = MAX_BITS - 1;
	localparam logic [OFF_W-1:0] TOTAL_MINUS = 7'(TOTAL_MINUS_I);

	// minimum search key: offset prefix sum above a tie-break index
	localparam int KEY_W = OFF_W + POS_W;

	// min tree split: groups reduced in the first stage
	localparam int GROUP_SIZE = 8;
	localparam int GROUPS     = MAX_BITS / GROUP_SIZE;

	// length after reset
	localparam logic [LEN_W-1:0] LEN_RESET = 6'd31;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [OFF_W-1:0]    psum_t;
	typedef logic [MAX_BITS-1:0] word_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [LEN_W-1:0]    len_t;

endpackage

// ----- hw/rtl/cyclic_bracket_match_flip_core.sv -----
// top level of the cyclic bracket match flip core
// depends on cbmf_pkg and cyclic_bracket_match_flip_core_macros.svh
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    word_bits, cmd
//   result    out        out_valid / out_ready  next_word, flip_position, match_error
//   config    in         cfg_wr_en              cfg_wr_data (active length)
//
// one word per cycle sustained while out_ready is held high; each accepted word
// passes through four register stages in all on its way to the outputs
// stage 1 holds the word, stage 2 the prefix-sum search keys, stage 3 the
// group minima of eight, stage 4 the result register
// each stage refills as soon as it empties or passes its word on, so a
// stalled result holds only the stages behind it that are full
// reset empties every stage and sets the active length to 31
`include "cyclic_bracket_match_flip_core_macros.svh"

module cyclic_bracket_match_flip_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic [cbmf_pkg::LEN_W-1:0]            cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [cbmf_pkg::MAX_BITS-1:0]         word_bits,
	input  logic                                  cmd,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [cbmf_pkg::MAX_BITS-1:0]         next_word,
	output logic [cbmf_pkg::POS_W-1:0]            flip_position,
	output logic                                  match_error
);

	// length register
	cbmf_pkg::len_t active_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_length_q <= cbmf_pkg::LEN_RESET;
		end else if (cfg_wr_en) begin
			active_length_q <= cfg_wr_data;
		end
	end

	// stage valids and per-stage ready
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: input word
	cbmf_pkg::word_t word_s1;
	logic            cmd_s1;
	cbmf_pkg::len_t  len_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			word_s1 <= word_bits;
			cmd_s1  <= cmd;
			len_s1  <= active_length_q;
		end
	end

	// opener bits and offset prefix sums P(k) + 32 for k = 0..32
	cbmf_pkg::word_t opener_c;
	cbmf_pkg::word_t used_mask_c;
	cbmf_pkg::psum_t psum_c [0:cbmf_pkg::MAX_BITS];
	cbmf_pkg::psum_t total_c;
	logic            len_bad_c;
	logic            err_c;
	logic            use_last_c;
	cbmf_pkg::key_t  keys_c [0:cbmf_pkg::MAX_BITS-1];

	assign opener_c = cmd_s1 ? word_s1 : ~word_s1;

	always_comb begin
		for (int k = 0; k <= cbmf_pkg::MAX_BITS; k++) begin
			logic [cbmf_pkg::MAX_BITS-1:0] pmask;
			logic [cbmf_pkg::LEN_W-1:0]    cnt;
			pmask = cbmf_pkg::MAX_BITS'(({1'b0, {cbmf_pkg::MAX_BITS{1'b1}}} << k)
				^ {1'b0, {cbmf_pkg::MAX_BITS{1'b1}}});
			cnt = cbmf_pkg::LEN_W'($countones(opener_c & pmask));
			psum_c[k] = {cnt, 1'b0} + cbmf_pkg::P_OFFSET - cbmf_pkg::OFF_W'(k);
		end
	end

	// length checks, total and word mask
	assign len_bad_c   = !len_s1[0] || (len_s1 > cbmf_pkg::LEN_W'(cbmf_pkg::MAX_BITS));
	assign total_c     = psum_c[len_s1];
	assign use_last_c  = (total_c == cbmf_pkg::TOTAL_PLUS);
	assign err_c       = len_bad_c
		|| ((total_c != cbmf_pkg::TOTAL_PLUS) && (total_c != cbmf_pkg::TOTAL_MINUS));
	assign used_mask_c = (len_s1 >= cbmf_pkg::LEN_W'(cbmf_pkg::MAX_BITS))
		? {cbmf_pkg::MAX_BITS{1'b1}}
		: cbmf_pkg::MAX_BITS'(({1'b0, {cbmf_pkg::MAX_BITS{1'b1}}} << len_s1)
			^ {1'b0, {cbmf_pkg::MAX_BITS{1'b1}}});

	// search keys: surplus opener takes the last minimum of P(j),
	// surplus closer the first minimum of P(j+1); unused positions max out
	always_comb begin
		for (int j = 0; j < cbmf_pkg::MAX_BITS; j++) begin
			if (cbmf_pkg::LEN_W'(j) < len_s1) begin
				if (use_last_c) begin
					keys_c[j] = {psum_c[j], ~cbmf_pkg::POS_W'(j)};
				end else begin
					keys_c[j] = {psum_c[j+1], cbmf_pkg::POS_W'(j)};
				end
			end else begin
				keys_c[j] = {cbmf_pkg::KEY_W{1'b1}};
			end
		end
	end

	// stage 2: keys and word
	cbmf_pkg::key_t  keys_s2 [0:cbmf_pkg::MAX_BITS-1];
	cbmf_pkg::word_t masked_s2, masked_s3, masked_s4;
	logic            use_last_s2, use_last_s3;
	logic            err_s2, err_s3;
	cbmf_pkg::len_t  len_s2, len_s3, len_s4;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			keys_s2     <= keys_c;
			masked_s2   <= word_s1 & used_mask_c;
			use_last_s2 <= use_last_c;
			err_s2      <= err_c;
			len_s2      <= len_s1;
		end
	end

	// group minima of eight keys
	cbmf_pkg::key_t gmin_c [0:cbmf_pkg::GROUPS-1];

	always_comb begin
		for (int g = 0; g < cbmf_pkg::GROUPS; g++) begin
			gmin_c[g] = keys_s2[g*cbmf_pkg::GROUP_SIZE];
			for (int e = 1; e < cbmf_pkg::GROUP_SIZE; e++) begin
				if (keys_s2[g*cbmf_pkg::GROUP_SIZE+e] < gmin_c[g]) begin
					gmin_c[g] = keys_s2[g*cbmf_pkg::GROUP_SIZE+e];
				end
			end
		end
	end

	// stage 3: group minima
	cbmf_pkg::key_t gmin_s3 [0:cbmf_pkg::GROUPS-1];

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			gmin_s3     <= gmin_c;
			masked_s3   <= masked_s2;
			use_last_s3 <= use_last_s2;
			err_s3      <= err_s2;
			len_s3      <= len_s2;
		end
	end

	// overall minimum and the flipped word
	cbmf_pkg::key_t  kmin_c;
	cbmf_pkg::pos_t  pos_c;
	cbmf_pkg::word_t flipped_c;

	always_comb begin
		kmin_c = gmin_s3[0];
		for (int g = 1; g < cbmf_pkg::GROUPS; g++) begin
			if (gmin_s3[g] < kmin_c) begin
				kmin_c = gmin_s3[g];
			end
		end
	end

	assign pos_c = use_last_s3 ? ~kmin_c[cbmf_pkg::POS_W-1:0] : kmin_c[cbmf_pkg::POS_W-1:0];
	assign flipped_c = masked_s3 ^ (cbmf_pkg::MAX_BITS'(1) << pos_c);

	// stage 4: result register
	cbmf_pkg::word_t next_word_s4;
	cbmf_pkg::pos_t  flip_position_s4;
	logic            match_error_s4;

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3) begin
			next_word_s4     <= err_s3 ? masked_s3 : flipped_c;
			flip_position_s4 <= err_s3 ? '0 : pos_c;
			match_error_s4   <= err_s3;
			masked_s4        <= masked_s3;
			len_s4           <= len_s3;
		end
	end

	assign out_valid     = valid_s4;
	assign next_word     = next_word_s4;
	assign flip_position = flip_position_s4;
	assign match_error   = match_error_s4;

	// checks
	`CBMF_ASSERT_NOW(a_err_pos_zero, valid_s4 && match_error_s4,
		flip_position_s4 == '0, "flip position not zero on error")
	`CBMF_ASSERT_NOW(a_pos_in_range, valid_s4 && !match_error_s4,
		(len_s4[0] == 1'b1) && (cbmf_pkg::LEN_W'(flip_position_s4) < len_s4),
		"flip outside odd active length")
	`CBMF_ASSERT_NOW(a_one_bit_flip, valid_s4 && !match_error_s4,
		$countones(next_word_s4 ^ masked_s4) == 1,
		"result differs from word in other than one bit")
	`CBMF_ASSERT_NEXT(a_stage_advance, valid_s3 && ready_s4, valid_s4,
		"stage 3 word lost on its way to the result")

endmodule
